@@ rtl/core/svp_pkg.sv @@
// Package for the stride value predictor: shared types, codes and defaults.
// Depends on nothing; used by every module under rtl/core.
package svp_pkg;

  localparam int unsigned DefaultSets      = 256;
  localparam int unsigned DefaultWays      = 4;
  localparam int unsigned DefaultAddrShift = 3;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned XWidth     = 8;
  localparam int unsigned ConfWidth  = 2;

  typedef enum logic [0:0] {
    FUNC_LOOKUP = 1'b0,
    FUNC_UNDO   = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_MISS  = 2'd0,
    STATUS_HIT   = 2'd1,
    STATUS_WRONG = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PREDICTOR_ENABLE   = 3'd0,
    REG_STRIDE_ENABLE      = 3'd1,
    REG_LOOKAHEAD_ENABLE   = 3'd2,
    REG_CONFIDENCE_ENABLE  = 3'd3,
    REG_REPLACE_LRU        = 3'd4,
    REG_INITIAL_CONFIDENCE = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_OUTPUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request and start the set read
    logic update;  // evaluate the set, write back, fill the result register
    logic bypass;  // predictor disabled: result is all zero, no state change
  } svp_cmd_t;

  typedef struct packed {
    logic enable;
    logic stride_en;
    logic lookahead_en;
    logic confidence_en;
    logic replace_lru;
    logic [ConfWidth-1:0] init_conf;
  } svp_cfg_t;

endpackage

@@ rtl/core/svp_ctrl.sv @@
// Controller state machine of the stride value predictor.
// Depends on svp_pkg; drives the datapath through svp_cmd_t.
module svp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              enable,
  input  logic              out_taken,
  input  logic              clear_busy,
  output logic              in_ready,
  output logic              out_valid,
  output svp_pkg::svp_cmd_t cmd
);

  svp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The result register frees as it is taken, so a new request is accepted
  // in the same cycle the old result leaves. Nothing is accepted while the
  // datapath is still clearing its valid bits after reset.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      svp_pkg::ST_IDLE: begin
        in_ready = !clear_busy;
      end
      svp_pkg::ST_READ: begin
        state_next = svp_pkg::ST_UPDATE;
      end
      svp_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = svp_pkg::ST_OUTPUT;
      end
      svp_pkg::ST_OUTPUT: begin
        out_valid = 1'b1;
        in_ready  = out_taken;
        if (out_taken) begin
          state_next = svp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = svp_pkg::ST_IDLE;
      end
    endcase
    if (in_ready && in_fire) begin
      cmd.load = 1'b1;
      if (enable) begin
        state_next = svp_pkg::ST_READ;
      end else begin
        cmd.bypass = 1'b1;
        state_next = svp_pkg::ST_OUTPUT;
      end
    end
  end

endmodule

@@ rtl/core/svp_datapath.sv @@
// Datapath of the stride value predictor: set memory, tag match, victim
// choice, prediction and training. Depends on svp_pkg.
module svp_datapath #(
  parameter int unsigned SETS       = svp_pkg::DefaultSets,
  parameter int unsigned WAYS       = svp_pkg::DefaultWays,
  parameter int unsigned ADDR_SHIFT = svp_pkg::DefaultAddrShift
) (
  input  logic              clk,
  input  logic              rst,
  input  svp_pkg::svp_cmd_t cmd,
  input  svp_pkg::svp_cfg_t cfg,
  input  logic              func,
  input  logic [31:0]       instr_address,
  input  logic signed [31:0] actual_value,
  input  logic              prediction_issued,
  output logic              clear_busy,
  output logic [1:0]        status,
  output logic signed [31:0] predicted_value,
  output logic              use_prediction
);

  localparam int unsigned SetBits = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayBits = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VW = svp_pkg::ValueWidth;
  localparam int unsigned XW = svp_pkg::XWidth;
  localparam int unsigned CW = svp_pkg::ConfWidth;

  typedef struct packed {
    logic [VW-1:0] tag;
    logic [CW-1:0] conf;
    logic [XW-1:0] x;
    logic [VW-1:0] last;
    logic [VW-1:0] stride;
    logic [VW-1:0] stamp;
  } entry_t;

  // One memory per way, indexed by set; the valid bits of a set are one
  // word of a separate memory that is cleared one set per cycle after reset.
  entry_t way_mem [WAYS][SETS];
  entry_t rd      [WAYS];
  logic [WAYS-1:0] valid_mem [SETS];

  logic          req_func;
  logic          req_issued;
  logic [VW-1:0] req_tag;
  logic [VW-1:0] req_actual;
  logic [SetBits-1:0] req_set;
  logic [VW-1:0] ref_counter;
  logic [WAYS-1:0] set_valid;
  logic          clearing;
  logic [SetBits-1:0] clr_set;

  logic [VW-1:0] tag_in;
  logic [SetBits-1:0] set_in;

  assign tag_in = instr_address >> ADDR_SHIFT;
  assign set_in = (SETS > 1) ? SetBits'(tag_in % SETS) : '0;
  assign clear_busy = clearing;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_func   <= func;
      req_issued <= prediction_issued;
      req_tag    <= tag_in;
      req_actual <= actual_value;
      req_set    <= set_in;
    end
  end

  // Clearing pass: walks every set once after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_set  <= '0;
    end else if (clearing) begin
      clr_set <= clr_set + 1'b1;
      if (clr_set == SetBits'(SETS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Registered set read in the cycle after the request is taken.
  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) begin
      rd[w] <= way_mem[w][req_set];
    end
    set_valid <= valid_mem[req_set];
  end

  // Tag match.
  logic               hit;
  logic [WayBits-1:0] hit_way;
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (set_valid[w] && rd[w].tag == req_tag) begin
        hit     = 1'b1;
        hit_way = WayBits'(w);
      end
    end
  end

  // Victim choice: first invalid way, else the policy's minimum.
  logic               any_invalid;
  logic [WayBits-1:0] inv_way;
  logic [WayBits-1:0] pick;
  logic [CW-1:0]      min_c;
  logic [VW-1:0]      min_s;
  always_comb begin
    any_invalid = 1'b0;
    inv_way     = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!set_valid[w]) begin
        any_invalid = 1'b1;
        inv_way     = WayBits'(w);
      end
    end
    pick  = '0;
    min_c = rd[0].conf;
    min_s = rd[0].stamp;
    for (int w = 0; w < WAYS; w++) begin
      if (!cfg.replace_lru && rd[w].conf < min_c) begin
        min_c = rd[w].conf;
        min_s = rd[w].stamp;
        pick  = WayBits'(w);
      end else if ((cfg.replace_lru || rd[w].conf == min_c) &&
                   ($signed(rd[w].stamp) < $signed(min_s))) begin
        min_s = rd[w].stamp;
        pick  = WayBits'(w);
      end
    end
  end

  // Prediction and training of the hit entry; also the fresh entry for a miss and the undone entry.
  entry_t        he;
  logic [VW-1:0] step;
  logic [VW-1:0] pred;
  logic          use_flag;
  logic          correct;
  logic [XW-1:0] x_inc;
  entry_t        trained;
  entry_t        fresh;
  entry_t        undone;
  always_comb begin
    he       = rd[hit_way];
    step     = cfg.lookahead_en ? VW'(he.x * he.stride) : he.stride;
    pred     = he.last + (cfg.stride_en ? step : '0);
    use_flag = cfg.confidence_en ? he.conf[CW-1] : 1'b1;
    correct  = (pred == req_actual);
    x_inc    = he.x + 1'b1;

    trained = he;
    if (correct) begin
      if (he.conf != '1) trained.conf = he.conf + 1'b1;
    end else begin
      if (he.conf != '0) trained.conf = he.conf - 1'b1;
    end
    trained.x      = (x_inc > XW'(1) && use_flag) ? x_inc - 1'b1 : x_inc;
    trained.stride = req_actual - he.last;
    trained.last   = req_actual;
    trained.stamp  = ref_counter;

    fresh.tag    = req_tag;
    fresh.conf   = cfg.init_conf;
    fresh.x      = XW'(1);
    fresh.last   = req_actual;
    fresh.stride = '0;
    fresh.stamp  = ref_counter;

    undone = he;
    if (he.x > XW'(1) && req_issued) undone.x = he.x - 1'b1;
  end

  logic               wr_en;
  logic [WayBits-1:0] wr_way;
  entry_t             wr_data;
  logic [WAYS-1:0]    way_bit;
  always_comb begin
    wr_en   = cmd.update;
    wr_way  = hit_way;
    wr_data = trained;
    if (req_func == svp_pkg::FUNC_UNDO) begin
      wr_en   = cmd.update && hit;
      wr_data = undone;
    end else if (!hit) begin
      wr_way  = any_invalid ? inv_way : pick;
      wr_data = fresh;
    end
    way_bit         = '0;
    way_bit[wr_way] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      way_mem[wr_way][req_set] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      valid_mem[clr_set] <= '0;
    end else if (cmd.update && req_func == svp_pkg::FUNC_LOOKUP) begin
      valid_mem[req_set] <= set_valid | way_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_counter <= '0;
    end else if (cmd.update && req_func == svp_pkg::FUNC_LOOKUP) begin
      ref_counter <= ref_counter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bypass) begin
      status          <= svp_pkg::STATUS_MISS;
      predicted_value <= '0;
      use_prediction  <= 1'b0;
    end else if (cmd.update) begin
      status          <= svp_pkg::STATUS_MISS;
      predicted_value <= '0;
      use_prediction  <= 1'b0;
      if (hit) begin
        if (req_func == svp_pkg::FUNC_UNDO) begin
          status <= svp_pkg::STATUS_HIT;
        end else begin
          status          <= correct ? svp_pkg::STATUS_HIT : svp_pkg::STATUS_WRONG;
          predicted_value <= pred;
          use_prediction  <= use_flag;
        end
      end
    end
  end

endmodule

@@ rtl/core/stride_value_predictor_top.sv @@
// Top level of the set-associative stride value predictor.
// Depends on svp_pkg, svp_ctrl and svp_datapath.
//
//  Channel | Direction | Handshake             | Payload
//  s_axis  | in        | s_tvalid / s_tready   | s_tuser=func, s_tdata
//  m_axis  | out       | m_tvalid / m_tready   | m_tdata
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// After acceptance, a lookup or undo request first reads the set from the
// per-way memories, then matches tags, picks a victim, forms the prediction,
// writes the trained entry back and loads the result register. The set
// memory's single read port and write-back sequence the requests one at a
// time, so a new request is accepted only once the last result is taken.
// With the predictor disabled the result appears in the next cycle. A
// stalled result holds the block; the next request is taken in the same
// cycle the result is taken. Reset is synchronous; it clears the stamp
// counter and resets the controller state and the configuration registers,
// then a clearing pass over all SETS sets (256 by default) zeroes the valid
// bits one set per cycle; s_tready stays low until it ends.
module stride_value_predictor_top #(
  parameter int unsigned SETS       = svp_pkg::DefaultSets,
  parameter int unsigned WAYS       = svp_pkg::DefaultWays,
  parameter int unsigned ADDR_SHIFT = svp_pkg::DefaultAddrShift
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // instr_address[31:0], actual_value[63:32],
                                 // prediction_issued[64], zero fill above
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status[1:0], predicted_value[33:2],
                                 // use_prediction[34], zero fill above
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  svp_pkg::svp_cfg_t cfg;
  svp_pkg::svp_cmd_t cmd;
  logic [1:0]        status;
  logic signed [31:0] predicted_value;
  logic              use_prediction;
  logic              clear_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable        <= 1'b1;
      cfg.stride_en     <= 1'b1;
      cfg.lookahead_en  <= 1'b0;
      cfg.confidence_en <= 1'b1;
      cfg.replace_lru   <= 1'b1;
      cfg.init_conf     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        svp_pkg::REG_PREDICTOR_ENABLE:   cfg.enable        <= cfg_data[0];
        svp_pkg::REG_STRIDE_ENABLE:      cfg.stride_en     <= cfg_data[0];
        svp_pkg::REG_LOOKAHEAD_ENABLE:   cfg.lookahead_en  <= cfg_data[0];
        svp_pkg::REG_CONFIDENCE_ENABLE:  cfg.confidence_en <= cfg_data[0];
        svp_pkg::REG_REPLACE_LRU:        cfg.replace_lru   <= cfg_data[0];
        svp_pkg::REG_INITIAL_CONFIDENCE: cfg.init_conf     <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  svp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (s_tvalid),
    .enable     (cfg.enable),
    .out_taken  (m_tready),
    .clear_busy (clear_busy),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .cmd        (cmd)
  );

  svp_datapath #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .ADDR_SHIFT (ADDR_SHIFT)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg               (cfg),
    .func              (s_tuser),
    .instr_address     (s_tdata[31:0]),
    .actual_value      (s_tdata[63:32]),
    .prediction_issued (s_tdata[64]),
    .clear_busy        (clear_busy),
    .status            (status),
    .predicted_value   (predicted_value),
    .use_prediction    (use_prediction)
  );

  assign m_tdata = {5'd0, use_prediction, predicted_value, status};

endmodule
